// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/stms_pkg.sv -----
// Shared types and constants for the sorted table membership search.
package stms_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_QUERY = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_Q_PROBE,
        ST_Q_CHECK,
        ST_L_PROBE,
        ST_L_CHECK,
        ST_SHIFT,
        ST_PLACE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch key, open search range
        logic clear;     // empty table, drop overflow flag
        logic set_ovf;   // load into full table
        logic probe;     // read table at range midpoint
        logic step;      // narrow range after a probe
        logic go_right;  // narrow to upper half
        logic shift;     // move one key up per beat
        logic place;     // write key at insert slot
        logic report;    // emit result beat
        logic hit;       // found value of that beat
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic table_full;
        logic range_empty;
        logic key_eq;
        logic key_lt;
        logic key_gt;
        logic shift_done;
    } dp_status_t;

endpackage

// ----- rtl/stms_ram.sv -----
// Generic simple dual-port RAM with registered read.
module stms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/stms_dp.sv -----
// Datapath: key table, search range, insert shifter and result registers.
module stms_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  stms_pkg::dp_cmd_t               cmd,
    output stms_pkg::dp_status_t            status,
    input  logic signed [stms_pkg::KEY_W-1:0] key_value,
    output logic                            done,
    output logic                            found,
    output logic                            overflowed
);
    import stms_pkg::*;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    ovf_reg, ovf_next;
    logic [CNT_W-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]        hi_reg, hi_next;
    logic [ADDR_W-1:0]       mid_reg, mid_next;
    logic [CNT_W-1:0]        src_reg, src_next;
    logic                    pend_reg, pend_next;
    logic [ADDR_W-1:0]       pend_addr_reg, pend_addr_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic                    done_reg, done_next;
    logic                    found_reg, found_next;
    logic                    ovf_out_reg, ovf_out_next;

    logic [CNT_W-1:0]        mid_w;
    logic [CNT_W-1:0]        src_m1;
    logic                    read_now;
    logic                    ram_we, ram_re;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [KEY_W-1:0]        ram_wdata, ram_rdata;
    logic signed [KEY_W-1:0] mk;

    assign mid_w    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign src_m1   = src_reg - 1'b1;
    assign read_now = cmd.shift && (src_reg > lo_reg);
    assign mk       = $signed(ram_rdata);

    // read port: probe at midpoint, or next key to move up
    assign ram_re    = cmd.probe || read_now;
    assign ram_raddr = cmd.probe ? mid_w[ADDR_W-1:0] : src_m1[ADDR_W-1:0];

    // write port: shifted key from the RAM read data at the pending address, or the new key
    assign ram_we    = (cmd.shift && pend_reg) || cmd.place;
    assign ram_waddr = cmd.place ? lo_reg[ADDR_W-1:0] : pend_addr_reg;
    assign ram_wdata = cmd.place ? key_reg : ram_rdata;

    stms_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        status.table_full  = (count_reg == CNT_W'(TABLE_DEPTH));
        status.range_empty = (lo_reg >= hi_reg);
        status.key_eq      = (key_reg == mk);
        status.key_lt      = (key_reg < mk);
        status.key_gt      = (key_reg > mk);
        status.shift_done  = !(src_reg > lo_reg) && !pend_reg;
    end

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        src_next       = src_reg;
        key_next       = key_reg;
        pend_next      = read_now;
        pend_addr_next = pend_addr_reg;
        done_next      = cmd.report;
        found_next     = found_reg;
        ovf_out_next   = ovf_out_reg;

        if (cmd.capture)
        begin
            key_next = key_value;
            lo_next  = '0;
            hi_next  = count_reg;
            src_next = count_reg;
        end
        if (cmd.clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        if (cmd.set_ovf)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.probe)
        begin
            mid_next = mid_w[ADDR_W-1:0];
        end
        if (cmd.step)
        begin
            if (cmd.go_right)
            begin
                lo_next = {1'b0, mid_reg} + 1'b1;
            end
            else
            begin
                hi_next = {1'b0, mid_reg};
            end
        end
        if (read_now)
        begin
            src_next       = src_m1;
            pend_addr_next = src_reg[ADDR_W-1:0];
        end
        if (cmd.place)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.report)
        begin
            found_next   = cmd.hit;
            ovf_out_next = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        src_reg       <= src_next;
        pend_addr_reg <= pend_addr_next;
        key_reg       <= key_next;
        found_reg     <= found_next;
        ovf_out_reg   <= ovf_out_next;
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign overflowed = ovf_out_reg;

endmodule

// ----- rtl/stms_ctrl.sv -----
// Controller state machine sequencing search, insert shift and result beats.
module stms_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           func,
    input  stms_pkg::dp_status_t status,
    output stms_pkg::dp_cmd_t    cmd,
    output logic                 busy
);
    import stms_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_QUERY)
                    begin
                        state_next = ST_Q_PROBE;
                    end
                    else if (func == FUNC_LOAD && !status.table_full)
                    begin
                        state_next = ST_L_PROBE;
                    end
                end
            end
            ST_Q_PROBE: state_next = status.range_empty ? ST_IDLE : ST_Q_CHECK;
            ST_Q_CHECK: state_next = status.key_eq ? ST_IDLE : ST_Q_PROBE;
            ST_L_PROBE: state_next = status.range_empty ? ST_SHIFT : ST_L_CHECK;
            ST_L_CHECK: state_next = ST_L_PROBE;
            ST_SHIFT:   state_next = status.shift_done ? ST_PLACE : ST_SHIFT;
            ST_PLACE:   state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_CLEAR: cmd.clear   = 1'b1;
                        FUNC_LOAD:
                        begin
                            cmd.set_ovf = status.table_full;
                            cmd.capture = !status.table_full;
                        end
                        FUNC_QUERY: cmd.capture = 1'b1;
                        default:    cmd.capture = 1'b0;
                    endcase
                end
            end
            ST_Q_PROBE:
            begin
                cmd.probe  = !status.range_empty;
                cmd.report = status.range_empty;
            end
            ST_Q_CHECK:
            begin
                cmd.report   = status.key_eq;
                cmd.hit      = status.key_eq;
                cmd.step     = !status.key_eq;
                cmd.go_right = status.key_gt;
            end
            ST_L_PROBE: cmd.probe = !status.range_empty;
            ST_L_CHECK:
            begin
                // upper bound: equal keys stay to the left of the slot
                cmd.step     = 1'b1;
                cmd.go_right = !status.key_lt;
            end
            ST_SHIFT:   cmd.shift = 1'b1;
            ST_PLACE:   cmd.place = 1'b1;
            default:    cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- rtl/sorted_table_membership_search.sv -----
// Top level of the sorted table membership search: controller, datapath, checks.
// Query: done strobes after a binary search of P <= log2(depth) + 1 probes; each probe
//   is a RAM read plus a compare.
// Load: a binary search for the insert slot, the M keys above it move up, the new key is
//   written; no beat. Clear, full-table load and unused code end in the start cycle, no beat.
// One item at a time; async rst_n empties the table and the flag; done cannot be stalled.
`include "assert_macros.svh"

module sorted_table_membership_search (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      func,
    input  logic signed [stms_pkg::KEY_W-1:0] key_value,
    output logic                            done,
    output logic                            found,
    output logic                            overflowed
);
    import stms_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer: picks the operation on the start beat, walks the binary search
    // with a probe state and a check state per probe, then drives the insert shift for loads.
    stms_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Datapath: key table RAM, lo/hi search bounds, shift pointer with a
    // registered pending write, entry count, sticky overflow and result regs.
    stms_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .key_value  (key_value),
        .done       (done),
        .found      (found),
        .overflowed (overflowed)
    );

    // A result beat always follows work done while busy.
    `ASSERT_IMPL(a_done_after_busy, clk, rst_n, done, $past(busy), "result beat without work")
    // The start beat is taken in idle, where no result is issued.
    `ASSERT_NEXT(a_no_done_after_accept, clk, rst_n, start && !busy, !done, "unexpected beat")
    // Insert write only into a table with room, and it ends the operation.
    `ASSERT_IMPL(a_place_not_full, clk, rst_n, cmd.place, !status.table_full, "write past full")
    `ASSERT_NEXT(a_place_ends_op, clk, rst_n, cmd.place, !busy, "insert did not finish")

endmodule
